// File: design/bpls_pkg.sv
package bpls_pkg;

  // widest coordinate the pattern test handles, and the default width
  localparam int unsigned CoordMax     = 16;
  localparam int unsigned CoordDefault = 12;

  // function codes of an input word
  localparam logic FuncStart = 1'b0;
  localparam logic FuncStep  = 1'b1;

  // line styles, the spare code draws solid
  typedef enum logic [1:0] {
    STYLE_SOLID  = 2'd0,
    STYLE_DOTTED = 2'd1,
    STYLE_DASHED = 2'd2
  } style_e;

  // 4**k is 1 mod 3, so the base-4 digit sum keeps the residue
  function automatic logic is_mult3(logic [CoordMax-1:0] a);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < CoordMax / 2; i++) begin
      s = s + 5'(a[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    return (t == 3'd0) || (t == 3'd3) || (t == 3'd6);
  endfunction

  // 16**k is 1 mod 5, so the hex digit sum keeps the residue
  function automatic logic is_mult5(logic [CoordMax-1:0] a);
    logic [5:0] u;
    logic [4:0] v;
    u = '0;
    for (int i = 0; i < CoordMax / 4; i++) begin
      u = u + 6'(a[4*i +: 4]);
    end
    v = 5'(u[3:0]) + 5'(u[5:4]);
    return (v == 5'd0) || (v == 5'd5) || (v == 5'd10) || (v == 5'd15);
  endfunction

  function automatic logic is_mult10(logic [CoordMax-1:0] a);
    return !a[0] && is_mult5(a);
  endfunction

endpackage

// File: design/bpls_in_reg.sv
module bpls_in_reg #(
  parameter int unsigned COORD_WIDTH = bpls_pkg::CoordDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic signed [COORD_WIDTH-1:0] x_start_i,
  input  logic signed [COORD_WIDTH-1:0] y_start_i,
  input  logic signed [COORD_WIDTH-1:0] x_end_i,
  input  logic signed [COORD_WIDTH-1:0] y_end_i,
  input  logic        [1:0]             style_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output logic                          func_o,
  output logic signed [COORD_WIDTH-1:0] x_start_o,
  output logic signed [COORD_WIDTH-1:0] y_start_o,
  output logic signed [COORD_WIDTH-1:0] x_end_o,
  output logic signed [COORD_WIDTH-1:0] y_end_o,
  output logic        [1:0]             style_o
);

  logic                          valid_q, valid_d;
  logic                          load;
  logic                          func_q;
  logic signed [COORD_WIDTH-1:0] x_start_q, y_start_q, x_end_q, y_end_q;
  logic        [1:0]             style_q;

  // the held word leaves in the same cycle a new one lands
  assign in_stall_o = valid_q && !pop_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      func_q    <= func_i;
      x_start_q <= x_start_i;
      y_start_q <= y_start_i;
      x_end_q   <= x_end_i;
      y_end_q   <= y_end_i;
      style_q   <= style_i;
    end
  end

  assign valid_o   = valid_q;
  assign func_o    = func_q;
  assign x_start_o = x_start_q;
  assign y_start_o = y_start_q;
  assign x_end_o   = x_end_q;
  assign y_end_o   = y_end_q;
  assign style_o   = style_q;

endmodule

// File: design/bpls_core.sv
module bpls_core #(
  parameter int unsigned COORD_WIDTH = bpls_pkg::CoordDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          take_i,
  input  logic                          func_i,
  input  logic signed [COORD_WIDTH-1:0] x_start_i,
  input  logic signed [COORD_WIDTH-1:0] y_start_i,
  input  logic signed [COORD_WIDTH-1:0] x_end_i,
  input  logic signed [COORD_WIDTH-1:0] y_end_i,
  input  logic        [1:0]             style_i,
  output logic                          has_result_o,
  output logic signed [COORD_WIDTH-1:0] pixel_x_o,
  output logic signed [COORD_WIDTH-1:0] pixel_y_o,
  output logic                          plot_o,
  output logic                          last_pixel_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned EW = COORD_WIDTH + 3;
  localparam int unsigned CM = bpls_pkg::CoordMax;

  logic signed [W-1:0]  cur_major_q, cur_major_d;
  logic signed [W-1:0]  cur_minor_q, cur_minor_d;
  logic signed [W-1:0]  end_major_q, end_major_d;
  logic        [W-1:0]  delta_major_q, delta_major_d;
  logic        [W-1:0]  delta_minor_q, delta_minor_d;
  logic signed [EW-1:0] error_q, error_d;
  logic                 major_neg_q, major_neg_d;
  logic                 minor_neg_q, minor_neg_d;
  logic                 swapped_q, swapped_d;
  logic        [1:0]    style_q, style_d;
  logic                 active_q, active_d;

  // start path
  logic signed [W:0]    dx_s, dy_s;
  logic        [W:0]    dx_abs, dy_abs;
  logic        [W-1:0]  dx, dy;
  logic                 swap;
  logic signed [W-1:0]  maj_s, maj_e, min_s, min_e;
  logic        [W-1:0]  dmaj, dmin;
  logic signed [EW-1:0] err_init;

  // step path
  logic signed [W-1:0]  next_major;
  logic signed [EW-1:0] two_dmin, two_dmaj;
  logic        [W-1:0]  mag;
  logic        [CM-1:0] mag_ext;

  assign dx_s   = {x_end_i[W-1], x_end_i} - {x_start_i[W-1], x_start_i};
  assign dy_s   = {y_end_i[W-1], y_end_i} - {y_start_i[W-1], y_start_i};
  assign dx_abs = dx_s[W] ? -dx_s : dx_s;
  assign dy_abs = dy_s[W] ? -dy_s : dy_s;
  assign dx     = dx_abs[W-1:0];
  assign dy     = dy_abs[W-1:0];
  assign swap   = dy > dx;

  assign maj_s = swap ? y_start_i : x_start_i;
  assign maj_e = swap ? y_end_i   : x_end_i;
  assign min_s = swap ? x_start_i : y_start_i;
  assign min_e = swap ? x_end_i   : y_end_i;
  assign dmaj  = swap ? dy : dx;
  assign dmin  = swap ? dx : dy;

  assign err_init = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});

  assign next_major = major_neg_q ? cur_major_q - W'(1) : cur_major_q + W'(1);
  assign two_dmin   = $signed({2'b00, delta_minor_q, 1'b0});
  assign two_dmaj   = $signed({2'b00, delta_major_q, 1'b0});

  // magnitude and signed value share their multiples of 3 and 10
  assign mag     = cur_major_q[W-1] ? -cur_major_q : cur_major_q;
  assign mag_ext = CM'(mag);

  always_comb begin
    unique case (style_q)
      bpls_pkg::STYLE_DOTTED: plot_o = !bpls_pkg::is_mult3(mag_ext);
      bpls_pkg::STYLE_DASHED: plot_o = !bpls_pkg::is_mult10(mag_ext);
      default:                plot_o = 1'b1;
    endcase
  end

  assign has_result_o = valid_i && (func_i == bpls_pkg::FuncStep) && active_q;
  assign pixel_x_o    = swapped_q ? cur_minor_q : cur_major_q;
  assign pixel_y_o    = swapped_q ? cur_major_q : cur_minor_q;
  assign last_pixel_o = next_major == end_major_q;

  always_comb begin
    cur_major_d   = cur_major_q;
    cur_minor_d   = cur_minor_q;
    end_major_d   = end_major_q;
    delta_major_d = delta_major_q;
    delta_minor_d = delta_minor_q;
    error_d       = error_q;
    major_neg_d   = major_neg_q;
    minor_neg_d   = minor_neg_q;
    swapped_d     = swapped_q;
    style_d       = style_q;
    active_d      = active_q;
    if (take_i) begin
      if (func_i == bpls_pkg::FuncStart) begin
        cur_major_d   = maj_s;
        end_major_d   = maj_e;
        cur_minor_d   = min_s;
        major_neg_d   = !(maj_s < maj_e);
        minor_neg_d   = !(min_s < min_e);
        delta_major_d = dmaj;
        delta_minor_d = dmin;
        swapped_d     = swap;
        style_d       = style_i;
        error_d       = err_init;
        active_d      = maj_s != maj_e;
      end else if (active_q) begin
        if (error_q[EW-1]) begin
          error_d = error_q + two_dmin;
        end else begin
          error_d     = error_q + two_dmin - two_dmaj;
          cur_minor_d = minor_neg_q ? cur_minor_q - W'(1) : cur_minor_q + W'(1);
        end
        cur_major_d = next_major;
        active_d    = next_major != end_major_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_major_q   <= '0;
      cur_minor_q   <= '0;
      end_major_q   <= '0;
      delta_major_q <= '0;
      delta_minor_q <= '0;
      error_q       <= '0;
      major_neg_q   <= 1'b0;
      minor_neg_q   <= 1'b0;
      swapped_q     <= 1'b0;
      style_q       <= '0;
      active_q      <= 1'b0;
    end else begin
      cur_major_q   <= cur_major_d;
      cur_minor_q   <= cur_minor_d;
      end_major_q   <= end_major_d;
      delta_major_q <= delta_major_d;
      delta_minor_q <= delta_minor_d;
      error_q       <= error_d;
      major_neg_q   <= major_neg_d;
      minor_neg_q   <= minor_neg_d;
      swapped_q     <= swapped_d;
      style_q       <= style_d;
      active_q      <= active_d;
    end
  end

endmodule

// File: design/bresenham_patterned_line_stepper.sv
// Bresenham line stepper with a solid, dotted or dashed pattern.
// Input channel (in_valid_i / in_stall_o): a word with func_i = 0 loads
// the endpoints and style_i and gives no result; func_i = 1 steps one pixel
// of the active line and gives one word on the output channel, or nothing
// when no line is active or the last pixel was already sent. The end point
// itself is never sent; last_pixel_o marks the pixel just before it.
// Output channel (out_valid_o / out_stall_i): pixel_x_o, pixel_y_o, plot_o
// (pattern shows this pixel) and last_pixel_o.
// A step word held in the input register passes to the result register, which
// drives the output. Throughput is one word per cycle while the output is not
// stalled; each step is one add and compare on the error term and the major
// coordinate, done between those two registers.
// Reset (rst_ni low) clears the line state: no line is active.
// A stall on the output holds the result register; the input register can
// still absorb one word, after which in_stall_o rises. Start words and
// steps that give nothing keep flowing while the output is stalled.
module bresenham_patterned_line_stepper #(
  parameter int unsigned COORD_WIDTH = bpls_pkg::CoordDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic signed [COORD_WIDTH-1:0] x_start_i,
  input  logic signed [COORD_WIDTH-1:0] y_start_i,
  input  logic signed [COORD_WIDTH-1:0] x_end_i,
  input  logic signed [COORD_WIDTH-1:0] y_end_i,
  input  logic        [1:0]             style_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] pixel_x_o,
  output logic signed [COORD_WIDTH-1:0] pixel_y_o,
  output logic                          plot_o,
  output logic                          last_pixel_o
);

  logic                          q_valid, q_func;
  logic signed [COORD_WIDTH-1:0] q_x_start, q_y_start, q_x_end, q_y_end;
  logic        [1:0]             q_style;
  logic                          has_result, advance, out_free, out_load;
  logic signed [COORD_WIDTH-1:0] res_x, res_y;
  logic                          res_plot, res_last;

  logic                          out_valid_q, out_valid_d;
  logic signed [COORD_WIDTH-1:0] pixel_x_q, pixel_y_q;
  logic                          plot_q, last_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = q_valid && (!has_result || out_free);
  assign out_load = advance && has_result;

  bpls_in_reg #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .x_start_i  (x_start_i),
    .y_start_i  (y_start_i),
    .x_end_i    (x_end_i),
    .y_end_i    (y_end_i),
    .style_i    (style_i),
    .pop_i      (advance),
    .valid_o    (q_valid),
    .func_o     (q_func),
    .x_start_o  (q_x_start),
    .y_start_o  (q_y_start),
    .x_end_o    (q_x_end),
    .y_end_o    (q_y_end),
    .style_o    (q_style)
  );

  bpls_core #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .take_i       (advance),
    .func_i       (q_func),
    .x_start_i    (q_x_start),
    .y_start_i    (q_y_start),
    .x_end_i      (q_x_end),
    .y_end_i      (q_y_end),
    .style_i      (q_style),
    .has_result_o (has_result),
    .pixel_x_o    (res_x),
    .pixel_y_o    (res_y),
    .plot_o       (res_plot),
    .last_pixel_o (res_last)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pixel_x_q <= res_x;
      pixel_y_q <= res_y;
      plot_q    <= res_plot;
      last_q    <= res_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pixel_x_q;
  assign pixel_y_o    = pixel_y_q;
  assign plot_o       = plot_q;
  assign last_pixel_o = last_q;

endmodule
